### design/fsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared widths, codes, types and small tables of the frame statistics
// decimator.
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam int MAX_DIM       = 1024;
	localparam int MAX_FACTOR    = 16;
	localparam int PREVIEW_LIMIT = 65467;

	localparam int PX_W     = 8;
	localparam int DIM_W    = 11;
	localparam int POS_W    = 10;
	localparam int PH_W     = 4;
	localparam int FAC_W    = 5;
	localparam int DEC_W    = 16;
	localparam int MODE_W   = 2;
	localparam int KIND_W   = 2;
	localparam int SUM_W    = 28;
	localparam int SAT_W    = 21;
	localparam int N_W      = 21;
	localparam int MEAN_W   = 16;
	localparam int SATQ_W   = 17;
	localparam int PROD_W   = 2 * DIM_W;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int RPROD_W     = DIM_W + RECIP_W;

	localparam int MEAN_FRAC = 8;
	localparam int SATQ_FRAC = 16;
	localparam int DIV_W     = SAT_W + SATQ_FRAC;
	localparam int REM_W     = N_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int MEAN_MAX  = 65535;
	localparam int SATQ_MAX  = 65536;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int SETTLE_CYCLES = 2;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STATS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RAW     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STATS   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PREVIEW = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DECIMATION = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FACTOR     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd4;

	localparam logic [MODE_W-1:0] RST_MODE       = 2'd0;
	localparam logic [DEC_W-1:0]  RST_DECIMATION = 16'd1;
	localparam logic [FAC_W-1:0]  RST_FACTOR     = 5'd1;
	localparam logic [DIM_W-1:0]  RST_WIDTH      = 11'd248;
	localparam logic [DIM_W-1:0]  RST_HEIGHT     = 11'd248;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DEC_W-1:0]  decim_m1;
		logic [FAC_W-1:0]  factor;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [N_W-1:0]    n_pix;
		logic              too_big;
		logic              busy;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PX_W-1:0]   px;
		logic              last;
		logic [PX_W-1:0]   peak;
		logic [SUM_W-1:0]  sum;
		logic [SAT_W-1:0]  sat;
		logic [N_W-1:0]    n_pix;
	} job_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		else r = v;
		return r;
	endfunction

	function automatic logic [FAC_W-1:0] clamp_factor(input logic [FAC_W-1:0] v);
		logic [FAC_W-1:0] r;
		if (v == '0) r = FAC_W'(1);
		else if (v > FAC_W'(MAX_FACTOR)) r = FAC_W'(MAX_FACTOR);
		else r = v;
		return r;
	endfunction

	// ceil(2^16 / f); exact floor division for dividends up to 1039
	function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
		logic [RECIP_W-1:0] r;
		case (f)
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21846;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13108;
			5'd6:    r = 17'd10923;
			5'd7:    r = 17'd9363;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7282;
			5'd10:   r = 17'd6554;
			5'd11:   r = 17'd5958;
			5'd12:   r = 17'd5462;
			5'd13:   r = 17'd5042;
			5'd14:   r = 17'd4682;
			5'd15:   r = 17'd4370;
			5'd16:   r = 17'd4096;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

### design/fsd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_regs
// Register file on the APB port, clamping and derived frame constants.
// ----------------------------------------------------------------------------
module fsd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [fsd_pkg::DATA_W-1:0]   pwdata,
	output logic [fsd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output fsd_pkg::cfg_t                cfg
);
	import fsd_pkg::*;

	logic [MODE_W-1:0]    mode_q;
	logic [DEC_W-1:0]     decim_q;
	logic [FAC_W-1:0]     factor_q;
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [SETTLE_W-1:0]  settle_q;

	logic [DIM_W-1:0]     wc_s1;
	logic [DIM_W-1:0]     hc_s1;
	logic [FAC_W-1:0]     fc_s1;
	logic [DEC_W-1:0]     decm1_s1;
	logic [N_W-1:0]       n_s1;
	logic [DIM_W-1:0]     cw_s1;
	logic [DIM_W-1:0]     ch_s1;
	logic                 too_big_s2;

	logic                 wr;
	logic [REG_IDX_W-1:0] idx;
	logic [DIM_W-1:0]     wcl;
	logic [DIM_W-1:0]     hcl;
	logic [FAC_W-1:0]     fcl;
	logic [DEC_W-1:0]     dcl;
	logic [RPROD_W-1:0]   cw_prod;
	logic [RPROD_W-1:0]   ch_prod;
	logic [PROD_W-1:0]    prev_pix;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	always_comb begin
		unique case (idx)
			REG_MODE:       prdata = DATA_W'(mode_q);
			REG_DECIMATION: prdata = DATA_W'(decim_q);
			REG_FACTOR:     prdata = DATA_W'(factor_q);
			REG_WIDTH:      prdata = DATA_W'(width_q);
			REG_HEIGHT:     prdata = DATA_W'(height_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_MODE;
			decim_q  <= RST_DECIMATION;
			factor_q <= RST_FACTOR;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else begin
			if (wr) begin
				settle_q <= SETTLE_W'(SETTLE_CYCLES);
				unique case (idx)
					REG_MODE:       mode_q   <= pwdata[MODE_W-1:0];
					REG_DECIMATION: decim_q  <= pwdata[DEC_W-1:0];
					REG_FACTOR:     factor_q <= pwdata[FAC_W-1:0];
					REG_WIDTH:      width_q  <= pwdata[DIM_W-1:0];
					REG_HEIGHT:     height_q <= pwdata[DIM_W-1:0];
					default:        ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	always_comb begin
		wcl      = clamp_dim(width_q);
		hcl      = clamp_dim(height_q);
		fcl      = clamp_factor(factor_q);
		dcl      = (decim_q == '0) ? DEC_W'(1) : decim_q;
		cw_prod  = RPROD_W'(wcl + DIM_W'(fcl) - DIM_W'(1)) * RPROD_W'(recip(fcl));
		ch_prod  = RPROD_W'(hcl + DIM_W'(fcl) - DIM_W'(1)) * RPROD_W'(recip(fcl));
		prev_pix = PROD_W'(cw_s1) * PROD_W'(ch_s1);
	end

	// derived values settle through the _s1 registers and then too_big_s2 after a write; busy covers that
	always_ff @(posedge clk) begin
		wc_s1      <= wcl;
		hc_s1      <= hcl;
		fc_s1      <= fcl;
		decm1_s1   <= dcl - DEC_W'(1);
		n_s1       <= N_W'(wcl) * N_W'(hcl);
		cw_s1      <= cw_prod[RECIP_SHIFT +: DIM_W];
		ch_s1      <= ch_prod[RECIP_SHIFT +: DIM_W];
		too_big_s2 <= prev_pix > PROD_W'(PREVIEW_LIMIT);
	end

	always_comb begin
		cfg.mode     = mode_q;
		cfg.decim_m1 = decm1_s1;
		cfg.factor   = fc_s1;
		cfg.width    = wc_s1;
		cfg.height   = hc_s1;
		cfg.n_pix    = n_s1;
		cfg.too_big  = too_big_s2;
		cfg.busy     = settle_q != '0;
	end

endmodule

### design/fsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_front
// Raster tracking, frame decimation, accumulation and job classification.
// ----------------------------------------------------------------------------
module fsd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fsd_pkg::cfg_t              cfg,
	input  logic                       push,
	input  logic [fsd_pkg::PX_W-1:0]   pixel,
	output logic                       full,
	input  logic                       q_full,
	output logic                       job_wr,
	output fsd_pkg::job_t              job
);
	import fsd_pkg::*;

	logic [DEC_W-1:0] skip_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [PH_W-1:0]  rph_q;
	logic [PH_W-1:0]  cph_q;
	logic             kept_q;
	logic [PX_W-1:0]  peak_q;
	logic [SUM_W-1:0] sum_q;
	logic [SAT_W-1:0] sat_q;

	logic             accept;
	logic             first;
	logic             preview;
	logic             keep_start;
	logic             err;
	logic             kept;
	logic [PX_W-1:0]  peak_b;
	logic [SUM_W-1:0] sum_b;
	logic [SAT_W-1:0] sat_b;
	logic [PH_W-1:0]  rph_b;
	logic [PH_W-1:0]  cph_b;
	logic [PX_W-1:0]  peak_n;
	logic [SUM_W-1:0] sum_n;
	logic [SAT_W-1:0] sat_n;
	logic             end_col;
	logic             end_row;
	logic             final_px;
	logic             prev_last;
	logic             has_job;
	logic [PH_W-1:0]  rph_inc;
	logic [PH_W-1:0]  cph_inc;

	assign full   = q_full || cfg.busy;
	assign accept = push && !full;

	always_comb begin
		first      = (row_q == '0) && (col_q == '0);
		preview    = (cfg.mode == MODE_PREVIEW) && (cfg.factor > FAC_W'(1));
		keep_start = skip_q == '0;
		err        = first && keep_start && preview && cfg.too_big;
		kept       = first ? (keep_start && !err) : kept_q;
		peak_b     = first ? '0 : peak_q;
		sum_b      = first ? '0 : sum_q;
		sat_b      = first ? '0 : sat_q;
		rph_b      = first ? '0 : rph_q;
		cph_b      = first ? '0 : cph_q;

		peak_n = (kept && (pixel > peak_b)) ? pixel : peak_b;
		sum_n  = kept ? sum_b + SUM_W'(pixel) : sum_b;
		sat_n  = (kept && (pixel == '1)) ? sat_b + SAT_W'(1) : sat_b;

		end_col   = (DIM_W'(col_q) + DIM_W'(1)) >= cfg.width;
		end_row   = (DIM_W'(row_q) + DIM_W'(1)) >= cfg.height;
		final_px  = end_col && end_row;
		prev_last = ((DIM_W'(row_q) + DIM_W'(cfg.factor)) >= cfg.height)
			&& ((DIM_W'(col_q) + DIM_W'(cfg.factor)) >= cfg.width);

		rph_inc = ((FAC_W'(rph_b) + FAC_W'(1)) >= cfg.factor) ? '0 : rph_b + PH_W'(1);
		cph_inc = ((FAC_W'(cph_b) + FAC_W'(1)) >= cfg.factor) ? '0 : cph_b + PH_W'(1);

		job     = '0;
		has_job = 1'b0;
		if (err) begin
			job.kind = KIND_ERROR;
			job.last = 1'b1;
			has_job  = 1'b1;
		end else if (kept) begin
			if (cfg.mode == MODE_STATS) begin
				if (final_px) begin
					job.kind  = KIND_STATS;
					job.last  = 1'b1;
					job.peak  = peak_n;
					job.sum   = sum_n;
					job.sat   = sat_n;
					job.n_pix = cfg.n_pix;
					has_job   = 1'b1;
				end
			end else if (preview) begin
				if ((rph_b == '0) && (cph_b == '0)) begin
					job.kind = KIND_PIXEL;
					job.px   = pixel;
					job.last = prev_last;
					has_job  = 1'b1;
				end
			end else begin
				job.kind = KIND_PIXEL;
				job.px   = pixel;
				job.last = final_px;
				has_job  = 1'b1;
			end
		end
		job_wr = accept && has_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			kept_q <= 1'b0;
			peak_q <= '0;
			sum_q  <= '0;
			sat_q  <= '0;
		end else if (accept) begin
			if (first) begin
				skip_q <= keep_start ? cfg.decim_m1 : skip_q - DEC_W'(1);
			end
			kept_q <= kept;
			peak_q <= peak_n;
			sum_q  <= sum_n;
			sat_q  <= sat_n;
			if (end_col) begin
				col_q <= '0;
				cph_q <= '0;
				if (end_row) begin
					row_q <= '0;
					rph_q <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
					rph_q <= rph_inc;
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				cph_q <= cph_inc;
				rph_q <= rph_b;
			end
		end
	end

endmodule

### design/fsd_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_job_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module fsd_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  fsd_pkg::job_t wdata,
	input  logic          rd,
	output fsd_pkg::job_t rdata,
	output logic          full,
	output logic          empty
);
	import fsd_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr && !rd) cnt_q <= cnt_q + QCNT_W'(1);
			else if (rd && !wr) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### design/fsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_back
// Executes jobs: pixel and error items pass to the output register, frame
// statistics run two restoring divisions on one shared divider.
// ----------------------------------------------------------------------------
module fsd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  fsd_pkg::job_t                job,
	output logic                         q_rd,
	input  logic                         pop,
	output logic                         empty,
	output logic [fsd_pkg::KIND_W-1:0]   kind,
	output logic [fsd_pkg::PX_W-1:0]     pixel_out,
	output logic [fsd_pkg::PX_W-1:0]     peak,
	output logic [fsd_pkg::MEAN_W-1:0]   mean_q8,
	output logic [fsd_pkg::SATQ_W-1:0]   saturated_q16,
	output logic                         last
);
	import fsd_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_MEAN = 3'b010,
		B_SAT  = 3'b100
	} bstate_t;

	bstate_t             state_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic [DIV_W-1:0]    dq_q;
	logic [REM_W-1:0]    rem_q;
	logic [N_W-1:0]      n_q;
	logic [PX_W-1:0]     peak_hold_q;
	logic [SAT_W-1:0]    sat_hold_q;
	logic [MEAN_W-1:0]   mean_hold_q;
	logic [KIND_W-1:0]   kind_q;
	logic [PX_W-1:0]     px_q;
	logic [PX_W-1:0]     peak_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [SATQ_W-1:0]   satq_q;
	logic                last_q;

	logic                pop_ok;
	logic                slot_free;
	logic                load_stats;
	logic                load_item;
	logic                div_done;
	logic                mean_done;
	logic                sat_done;
	logic [REM_W:0]      r2;
	logic                ge;
	logic [REM_W-1:0]    rem_n;
	logic [DIV_W-1:0]    dq_n;
	logic [MEAN_W-1:0]   mean_sat;
	logic [SATQ_W-1:0]   satq_sat;

	always_comb begin
		pop_ok     = pop && out_valid_q;
		slot_free  = !out_valid_q || pop_ok;
		q_rd       = (state_q == B_IDLE) && !q_empty && slot_free;
		load_stats = q_rd && (job.kind == KIND_STATS);
		load_item  = q_rd && (job.kind != KIND_STATS);
		div_done   = step_q == STEP_W'(DIV_STEPS - 1);
		mean_done  = (state_q == B_MEAN) && div_done;
		sat_done   = (state_q == B_SAT) && div_done;

		r2    = {rem_q, dq_q[DIV_W-1]};
		ge    = r2 >= (REM_W+1)'(n_q);
		rem_n = ge ? REM_W'(r2 - (REM_W+1)'(n_q)) : REM_W'(r2);
		dq_n  = {dq_q[DIV_W-2:0], ge};

		mean_sat = (dq_n > DIV_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX) : dq_n[MEAN_W-1:0];
		satq_sat = (dq_n > DIV_W'(SATQ_MAX)) ? SATQ_W'(SATQ_MAX) : dq_n[SATQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_item || sat_done) out_valid_q <= 1'b1;
			else if (pop_ok) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					step_q <= '0;
					if (load_stats) state_q <= B_MEAN;
				end
				B_MEAN: begin
					step_q <= div_done ? '0 : step_q + STEP_W'(1);
					if (div_done) state_q <= B_SAT;
				end
				B_SAT: begin
					step_q <= div_done ? '0 : step_q + STEP_W'(1);
					if (div_done) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_stats) begin
			dq_q        <= DIV_W'({job.sum, MEAN_FRAC'(0)});
			rem_q       <= '0;
			n_q         <= job.n_pix;
			peak_hold_q <= job.peak;
			sat_hold_q  <= job.sat;
		end else if (mean_done) begin
			mean_hold_q <= mean_sat;
			dq_q        <= {sat_hold_q, SATQ_FRAC'(0)};
			rem_q       <= '0;
		end else if ((state_q == B_MEAN) || (state_q == B_SAT)) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end

		if (load_item) begin
			kind_q <= job.kind;
			px_q   <= job.px;
			peak_q <= '0;
			mean_q <= '0;
			satq_q <= '0;
			last_q <= job.last;
		end else if (sat_done) begin
			kind_q <= KIND_STATS;
			px_q   <= '0;
			peak_q <= peak_hold_q;
			mean_q <= mean_hold_q;
			satq_q <= satq_sat;
			last_q <= 1'b1;
		end
	end

	assign empty         = !out_valid_q;
	assign kind          = kind_q;
	assign pixel_out     = px_q;
	assign peak          = peak_q;
	assign mean_q8       = mean_q;
	assign saturated_q16 = satq_q;
	assign last          = last_q;

endmodule

### design/frame_stats_decimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_decimator_unit
// Camera pixel frame decimator with raw, statistics and preview modes.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  pixels    push / full            pixel
//  results   pop / empty            kind, pixel_out, peak, mean_q8,
//                                   saturated_q16, last
//  config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
//  One pixel per clock enters the front while full is low; pixel items leave one per clock while pop is held.
//  A statistics item runs two divisions in the back (one shared
//  restoring divider, one quotient bit per cycle); a 4-entry job queue lets
//  the next frame stream meanwhile.
//  full is high after reset and after every register write
//  while derived frame constants settle, and whenever the job queue is full.
//  Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module frame_stats_decimator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [fsd_pkg::DATA_W-1:0]   pwdata,
	output logic [fsd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic [fsd_pkg::PX_W-1:0]     pixel,
	input  logic                         pop,
	output logic                         empty,
	output logic [fsd_pkg::KIND_W-1:0]   kind,
	output logic [fsd_pkg::PX_W-1:0]     pixel_out,
	output logic [fsd_pkg::PX_W-1:0]     peak,
	output logic [fsd_pkg::MEAN_W-1:0]   mean_q8,
	output logic [fsd_pkg::SATQ_W-1:0]   saturated_q16,
	output logic                         last
);
	import fsd_pkg::*;

	cfg_t cfg;
	job_t job_in;
	job_t job_out;
	logic job_wr;
	logic job_rd;
	logic q_full;
	logic q_empty;

	fsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.push   (push),
		.pixel  (pixel),
		.full   (full),
		.q_full (q_full),
		.job_wr (job_wr),
		.job    (job_in)
	);

	fsd_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_in),
		.rd     (job_rd),
		.rdata  (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	fsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.job           (job_out),
		.q_rd          (job_rd),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.pixel_out     (pixel_out),
		.peak          (peak),
		.mean_q8       (mean_q8),
		.saturated_q16 (saturated_q16),
		.last          (last)
	);

endmodule

### design/fsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the frame statistics decimator, bound to the top.
// ----------------------------------------------------------------------------
module fsd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic                         full,
	input logic                         pop,
	input logic                         empty,
	input logic [fsd_pkg::KIND_W-1:0]   kind,
	input logic [fsd_pkg::PX_W-1:0]     pixel_out,
	input logic [fsd_pkg::PX_W-1:0]     peak,
	input logic [fsd_pkg::MEAN_W-1:0]   mean_q8,
	input logic [fsd_pkg::SATQ_W-1:0]   saturated_q16,
	input logic                         last
);
	import fsd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(pixel_out) && $stable(last))
		else $error("result changed while stalled");

	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == KIND_ERROR) |-> last && (pixel_out == '0))
		else $error("error item malformed");

	a_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind != KIND_STATS) |->
			(peak == '0) && (mean_q8 == '0) && (saturated_q16 == '0))
		else $error("statistics fields set on a non-statistics item");

	a_stats_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == KIND_STATS) |->
			last && (pixel_out == '0) && (saturated_q16 <= SATQ_W'(SATQ_MAX)))
		else $error("statistics item malformed");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> full)
		else $error("input open right after a register write");

endmodule

bind frame_stats_decimator_unit fsd_checker u_fsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.full          (full),
	.pop           (pop),
	.empty         (empty),
	.kind          (kind),
	.pixel_out     (pixel_out),
	.peak          (peak),
	.mean_q8       (mean_q8),
	.saturated_q16 (saturated_q16),
	.last          (last)
);

### dv/frame_stats_decimator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_decimator_unit_tb
// Self-checking bench for the frame statistics decimator. A cycle-free model
// of the frame walk (countdown, raw pass, statistics, preview sampling and
// preview size error) predicts every result item from each accepted pixel;
// a checker pops results under random stalls and compares them field by
// field. Directed tests cover the extremes, then random small frames with
// random register settings make up the bulk.
// ----------------------------------------------------------------------------
module frame_stats_decimator_unit_tb;
	import fsd_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 350;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PX_W-1:0]   px;
		logic [PX_W-1:0]   peak;
		logic [MEAN_W-1:0] mean;
		logic [SATQ_W-1:0] satq;
		logic              last;
	} frame_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                push;
	logic                full;
	logic [PX_W-1:0]     pixel;
	logic                pop;
	logic                empty;
	logic [KIND_W-1:0]   kind;
	logic [PX_W-1:0]     pixel_out;
	logic [PX_W-1:0]     peak;
	logic [MEAN_W-1:0]   mean_q8;
	logic [SATQ_W-1:0]   saturated_q16;
	logic                last;

	// register copies
	logic [MODE_W-1:0] mode_cfg   = RST_MODE;
	logic [DEC_W-1:0]  decim_cfg  = RST_DECIMATION;
	logic [FAC_W-1:0]  factor_cfg = RST_FACTOR;
	logic [DIM_W-1:0]  width_cfg  = RST_WIDTH;
	logic [DIM_W-1:0]  height_cfg = RST_HEIGHT;

	// frame walk state
	logic [DEC_W-1:0] skip_cnt = '0;
	logic [POS_W-1:0] row_i    = '0;
	logic [POS_W-1:0] col_i    = '0;
	logic [PH_W-1:0]  row_ph   = '0;
	logic [PH_W-1:0]  col_ph   = '0;
	bit               kept     = 1'b0;
	logic [PX_W-1:0]  peak_acc = '0;
	logic [SUM_W-1:0] sum_acc  = '0;
	logic [SAT_W-1:0] sat_acc  = '0;

	frame_result_t results_due[$];
	int            mismatches  = 0;
	int            sent_pixels = 0;
	int            stall_left  = 0;
	bit            steady      = 1'b0;

	frame_stats_decimator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.pixel         (pixel),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.pixel_out     (pixel_out),
		.peak          (peak),
		.mean_q8       (mean_q8),
		.saturated_q16 (saturated_q16),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int dim_of(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [PX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return PX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_result(input logic [KIND_W-1:0] k, input logic [PX_W-1:0] px,
			input logic [PX_W-1:0] pk, input longint unsigned mq,
			input longint unsigned sq, input bit fin);
		frame_result_t r;
		r.kind = k;
		r.px   = px;
		r.peak = pk;
		r.mean = MEAN_W'(mq);
		r.satq = SATQ_W'(sq);
		r.last = fin;
		results_due.push_back(r);
	endtask

	task automatic predict_pixel(input logic [PX_W-1:0] v);
		int w, h, f;
		bit preview, end_col, end_row;
		longint unsigned n, mq, sq;
		sent_pixels++;
		w = dim_of(width_cfg);
		h = dim_of(height_cfg);
		f = (factor_cfg == '0) ? 1 : (factor_cfg > FAC_W'(MAX_FACTOR)) ? MAX_FACTOR :
			int'(factor_cfg);
		preview = (mode_cfg == MODE_PREVIEW) && (f > 1);
		if (row_i == '0 && col_i == '0) begin
			if (skip_cnt != '0) begin
				skip_cnt = skip_cnt - 1'b1;
				kept = 1'b0;
			end else begin
				skip_cnt = (decim_cfg == '0) ? '0 : decim_cfg - 1'b1;
				kept = 1'b1;
			end
			peak_acc = '0;
			sum_acc  = '0;
			sat_acc  = '0;
			row_ph   = '0;
			col_ph   = '0;
			if (kept && preview &&
					longint'((h + f - 1) / f) * longint'((w + f - 1) / f) > PREVIEW_LIMIT) begin
				kept = 1'b0;
				add_result(KIND_ERROR, '0, '0, 0, 0, 1'b1);
			end
		end
		end_col = int'(col_i) + 1 >= w;
		end_row = int'(row_i) + 1 >= h;
		if (kept) begin
			if (v > peak_acc) peak_acc = v;
			sum_acc += v;
			if (v == '1) sat_acc += 1'b1;
			if (mode_cfg == MODE_STATS) begin
				if (end_col && end_row) begin
					n  = longint'(w) * longint'(h);
					mq = (longint'(sum_acc) << MEAN_FRAC) / n;
					sq = (longint'(sat_acc) << SATQ_FRAC) / n;
					if (mq > MEAN_MAX) mq = MEAN_MAX;
					if (sq > SATQ_MAX) sq = SATQ_MAX;
					add_result(KIND_STATS, '0, peak_acc, mq, sq, 1'b1);
				end
			end else if (preview) begin
				if (row_ph == '0 && col_ph == '0)
					add_result(KIND_PIXEL, v, '0, 0, 0,
						(int'(row_i) + f >= h) && (int'(col_i) + f >= w));
			end else begin
				add_result(KIND_PIXEL, v, '0, 0, 0, end_col && end_row);
			end
		end
		if (end_col) begin
			col_i  = '0;
			col_ph = '0;
			if (end_row) begin
				row_i  = '0;
				row_ph = '0;
			end else begin
				row_i  = row_i + 1'b1;
				row_ph = (int'(row_ph) + 1 >= f) ? '0 : row_ph + 1'b1;
			end
		end else begin
			col_i  = col_i + 1'b1;
			col_ph = (int'(col_ph) + 1 >= f) ? '0 : col_ph + 1'b1;
		end
	endtask

	task automatic send_pixel(input logic [PX_W-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= v;
		do @(posedge clk); while (full);
		predict_pixel(v);
	endtask

	// fill < 0 draws random pixels, else the frame is filled with that value
	task automatic finish_frame(input int fill);
		do send_pixel(fill < 0 ? rand_pixel() : PX_W'(fill));
		while (row_i != '0 || col_i != '0);
	endtask

	task automatic settle_block();
		push <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MODE:       mode_cfg   = val[MODE_W-1:0];
			REG_DECIMATION: decim_cfg  = val[DEC_W-1:0];
			REG_FACTOR:     factor_cfg = val[FAC_W-1:0];
			REG_WIDTH:      width_cfg  = val[DIM_W-1:0];
			REG_HEIGHT:     height_cfg = val[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] d,
			input logic [DATA_W-1:0] f, input logic [DATA_W-1:0] w,
			input logic [DATA_W-1:0] h);
		settle_block();
		write_reg(REG_MODE, m);
		write_reg(REG_DECIMATION, d);
		write_reg(REG_FACTOR, f);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic test_raw_pass();
		set_config(MODE_RAW, 1, 1, 3, 2);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		send_pixel(8'h0F);
		send_pixel(8'hF0);
	endtask

	task automatic test_frame_stats();
		set_config(MODE_STATS, 1, 1, 1, 2);
		finish_frame(255);
		finish_frame(0);
		send_pixel(8'd7);
		send_pixel(8'd200);
	endtask

	task automatic test_preview();
		set_config(MODE_PREVIEW, 1, 2, 3, 1);
		finish_frame(-1);
		// factor saturates to 16
		set_config(MODE_PREVIEW, 1, 31, 1, 1);
		send_pixel(rand_pixel());
		// factor 0 acts as 1: raw pass
		set_config(MODE_PREVIEW, 1, 0, 1, 1);
		send_pixel(rand_pixel());
	endtask

	// too-large preview drops the frame, one just under the limit does not; shrink the frame to end it quickly
	task automatic test_preview_limit();
		set_config(MODE_PREVIEW, 1, 2, 512, 512);
		send_pixel(rand_pixel());
		set_config(MODE_PREVIEW, 1, 2, 1, 1);
		send_pixel(rand_pixel());
		set_config(MODE_PREVIEW, 1, 2, 510, 512);
		send_pixel(rand_pixel());
		set_config(MODE_PREVIEW, 1, 2, 1, 1);
		send_pixel(rand_pixel());
		set_config(MODE_PREVIEW, 1, 2, 2047, 2047);
		send_pixel(rand_pixel());
		set_config(MODE_PREVIEW, 1, 2, 1, 1);
		send_pixel(rand_pixel());
	endtask

	task automatic test_decimation();
		set_config(MODE_RAW, 3, 1, 1, 1);
		repeat (4) send_pixel(rand_pixel());
		settle_block();
		write_reg(REG_DECIMATION, 0);
		repeat (3) send_pixel(rand_pixel());
	endtask

	task automatic test_odd_codes();
		set_config(3, 0, 0, 0, 0);
		repeat (2) send_pixel(rand_pixel());
	endtask

	task automatic test_resize_mid_frame();
		set_config(MODE_RAW, 1, 1, 3, 2);
		repeat (2) send_pixel(rand_pixel());
		settle_block();
		write_reg(REG_WIDTH, 2);
		finish_frame(-1);
	endtask

	task automatic test_random_frames();
		int start;
		bit big;
		logic [DATA_W-1:0] w, h;
		start = sent_pixels;
		while (sent_pixels - start < RANDOM_ITEMS) begin
			big = ($urandom_range(0, 19) == 0);
			if (big) begin
				if ($urandom_range(0, 1)) begin
					w = 2047;
					h = 0;
				end else begin
					w = 1;
					h = 1024;
				end
			end else begin
				w = $urandom_range(0, 8);
				h = $urandom_range(0, 6);
			end
			set_config($urandom_range(0, 3), $urandom_range(0, 3),
				$urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 31), w, h);
			steady = ($urandom_range(0, 3) == 0);
			// a broken frame now and then: config then changes mid-frame;
			// oversized frames only see a short run of pixels
			if (big || $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 5)) send_pixel(rand_pixel());
			end else begin
				repeat ($urandom_range(1, 4)) finish_frame(-1);
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_longest_decimation();
		set_config(MODE_RAW, 65535, 1, 1, 1);
		repeat (4) send_pixel(rand_pixel());
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left = 0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected item kind %0d", $time, kind);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("pixel_out", want.px, pixel_out);
					check_field("peak", want.peak, peak);
					check_field("mean_q8", want.mean, mean_q8);
					check_field("saturated_q16", want.satq, saturated_q16);
					check_field("last", want.last, last);
				end
				stall_left = steady ? 0 : $urandom_range(0, 5);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			pop <= (stall_left == 0);
		end
	end

	initial begin
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		push    <= 1'b0;
		pixel   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_raw_pass();
		test_frame_stats();
		test_preview();
		test_preview_limit();
		test_decimation();
		test_odd_codes();
		test_resize_mid_frame();
		test_random_frames();
		test_longest_decimation();

		push <= 1'b0;
		for (int i = 0; i < 5000 && results_due.size() != 0; i++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, results_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
